>>> rtl/srgc_pkg.sv
// package for the shared resource grant check
// types, operation codes, register indexes and fixed field widths
// no dependencies
package srgc_pkg;

    localparam int ENTRY_W = 6;
    localparam int RING_W  = 7;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 32;
    localparam int INDEX_W = 3;

    localparam logic [TIME_W-1:0] MARGIN_LIMIT = 32'd150;
    localparam logic [3:0]        MARGIN_CAP   = 4'd15;
    localparam logic [7:0]        MARGIN_RECIP = 8'd205;
    localparam int                MARGIN_SHIFT = 11;

    typedef enum logic [1:0] {
        OP_QUERY    = 2'd0,
        OP_SET_RES  = 2'd1,
        OP_SET_WAIT = 2'd2,
        OP_SET_LEN  = 2'd3
    } op_t;

    localparam logic [INDEX_W-1:0] REG_RING     = 3'd0;
    localparam logic [INDEX_W-1:0] REG_BURNOUT  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_WORK     = 3'd2;
    localparam logic [INDEX_W-1:0] REG_COOLDOWN = 3'd3;
    localparam logic [INDEX_W-1:0] REG_POLICY   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RESOURCE,
        ST_PREP,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

>>> rtl/srgc_ring_wrap.sv
// registered (w + 1) mod ring for a wait list entry
// restoring reduction over ENTRY_W shift-and-subtract steps; uses srgc_pkg
module srgc_ring_wrap
    import srgc_pkg::*;
(
    input  logic                clk,
    input  logic [ENTRY_W-1:0]  w,
    input  logic [RING_W-1:0]   ring,
    output logic [RING_W-1:0]   wn
);

    localparam int RW = RING_W + ENTRY_W;

    logic [RW-1:0]     rem;
    logic [RING_W-1:0] wn_next;
    logic [RING_W-1:0] wn_reg;

    always_comb
    begin
        logic [RW-1:0] d;
        rem = RW'(w) + RW'(1);
        for (int k = ENTRY_W - 1; k >= 0; k--)
        begin
            d = RW'(ring) << k;
            if (rem >= d)
            begin
                rem = rem - d;
            end
        end
        wn_next = rem[RING_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        wn_reg <= wn_next;
    end

    assign wn = wn_reg;

endmodule

>>> rtl/shared_resource_grant_check.sv
// top level of the shared resource grant check
// resource and wait list memories, query sequencer; uses srgc_pkg, srgc_ring_wrap
//
// channel   signals                                    direction
// request   in_valid, in_ready, operation .. wait_length  in
// result    out_valid, out_ready, granted              out
// config    cfg_we, cfg_index, cfg_data                in
//
// writes (operations 1 to 3) finish in the decode state and pass through done to the result
// a query that ends before the scan passes decode, resource and prep, else it goes on to scan
// the wait list through the single read port of the wait list memory
// reset clears resource valid bits at once, so no clearing pass is needed
// the next request is taken while a result waits; it finishes once out_ready frees the register
module shared_resource_grant_check
    import srgc_pkg::*;
#(
    parameter int MAX_USERS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [ENTRY_W-1:0]  user_id,
    input  logic [TIME_W-1:0]   now_time,
    input  logic [TIME_W-1:0]   last_start_time,
    input  logic [ENTRY_W-1:0]  slot,
    input  logic                taken_flag,
    input  logic [TIME_W-1:0]   free_at_time,
    input  logic [ENTRY_W-1:0]  entry_user,
    input  logic [RING_W-1:0]   wait_length,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                granted,
    input  logic                cfg_we,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    localparam int IW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int CW = $clog2(MAX_USERS + 1);

    state_t state_reg, state_next;

    logic [RING_W-1:0] ring_size_reg;
    logic [TIME_W-1:0] burnout_reg, work_reg, cooldown_reg;
    logic              policy_reg;

    logic [CW-1:0]        wait_count_reg;
    logic [MAX_USERS-1:0] res_vld_reg;

    op_t               op_reg;
    logic [ENTRY_W-1:0] user_reg, slot_reg, entry_reg;
    logic [TIME_W-1:0] now_reg, last_reg, fat_reg;
    logic              flag_reg;
    logic [RING_W-1:0] wlen_reg;

    logic [RING_W-1:0] left_reg, right_reg, ring_eff_reg;
    logic              user_out_reg;
    logic [TIME_W-1:0] lived_reg, left_t_reg, thr_reg, sum_reg, need_reg;
    logic [3:0]        margin_reg;
    logic              lived_ge_reg, res_ok_reg, doom_base_reg;
    logic              grant_res_reg;

    logic [TIME_W:0]   res_mem [MAX_USERS];
    logic [TIME_W:0]   res_l_q, res_r_q;
    logic              vld_l_reg, vld_r_reg;

    logic [ENTRY_W-1:0] wl_mem [MAX_USERS];
    logic [ENTRY_W-1:0] wl_q;

    logic [CW-1:0]      rd_idx_reg;
    logic               p1_vld_reg, p2_vld_reg;
    logic [IW-1:0]      p1_idx_reg, p2_idx_reg;
    logic [ENTRY_W-1:0] w2_reg;
    logic [RING_W-1:0]  wn_q;

    logic out_valid_reg, granted_reg;

    logic              res_re, res_we, wl_we, wl_re, cnt_we, fin, fin_grant;
    logic              slot_ok;
    logic [RING_W-1:0] ring_eff, right_calc;
    logic [IW-1:0]     ra_l, ra_r;
    logic [15:0]       margin_prod;
    logic [3:0]        margin_calc;
    logic              taken_l, taken_r;
    logic [TIME_W-1:0] fa_l, fa_r;
    logic              clash, doom, last_entry;

    // effective ring size and neighbor of the requester
    always_comb
    begin
        if (ring_size_reg < RING_W'(2))
        begin
            ring_eff = RING_W'(2);
        end
        else if (32'(ring_size_reg) > MAX_USERS)
        begin
            ring_eff = RING_W'(MAX_USERS);
        end
        else
        begin
            ring_eff = ring_size_reg;
        end
        if (RING_W'(user_reg) + RING_W'(1) == ring_eff)
        begin
            right_calc = '0;
        end
        else
        begin
            right_calc = RING_W'(user_reg) + RING_W'(1);
        end
    end

    assign ra_l    = IW'(user_reg);
    assign ra_r    = IW'(right_calc);
    assign slot_ok = 32'(slot_reg) < MAX_USERS;

    // burnout / 10 capped at 15, by reciprocal below the cap
    assign margin_prod = 16'(burnout_reg[7:0]) * 16'(MARGIN_RECIP);
    assign margin_calc = (burnout_reg >= MARGIN_LIMIT) ? MARGIN_CAP
                                                       : margin_prod[MARGIN_SHIFT +: 4];

    assign taken_l = vld_l_reg & res_l_q[TIME_W];
    assign taken_r = vld_r_reg & res_r_q[TIME_W];
    assign fa_l    = vld_l_reg ? res_l_q[TIME_W-1:0] : '0;
    assign fa_r    = vld_r_reg ? res_r_q[TIME_W-1:0] : '0;

    assign clash = ({1'b0, w2_reg} == left_reg) || ({1'b0, w2_reg} == right_reg) ||
                   (wn_q == left_reg) || (wn_q == right_reg);
    assign doom  = doom_base_reg || (need_reg >= thr_reg);
    assign last_entry = (CW'(p2_idx_reg) + CW'(1)) == wait_count_reg;

    srgc_ring_wrap u_wrap
    (
        .clk  (clk),
        .w    (wl_q),
        .ring (ring_eff_reg),
        .wn   (wn_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        res_re     = 1'b0;
        res_we     = 1'b0;
        wl_we      = 1'b0;
        wl_re      = 1'b0;
        cnt_we     = 1'b0;
        fin        = 1'b0;
        fin_grant  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (op_reg)
                    OP_QUERY:
                    begin
                        res_re     = 1'b1;
                        state_next = ST_RESOURCE;
                    end
                    OP_SET_RES:
                    begin
                        res_we = slot_ok;
                        fin    = 1'b1;
                    end
                    OP_SET_WAIT:
                    begin
                        wl_we = slot_ok;
                        fin   = 1'b1;
                    end
                    OP_SET_LEN:
                    begin
                        cnt_we = 1'b1;
                        fin    = 1'b1;
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            ST_RESOURCE:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (user_out_reg || !res_ok_reg)
                begin
                    fin = 1'b1;
                end
                else if (wait_count_reg == '0)
                begin
                    fin       = 1'b1;
                    fin_grant = 1'b1;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                wl_re = rd_idx_reg < wait_count_reg;
                if (p2_vld_reg)
                begin
                    priority if (w2_reg == user_reg)
                    begin
                        fin       = 1'b1;
                        fin_grant = 1'b1;
                    end
                    else if (clash && !(policy_reg && doom))
                    begin
                        fin = 1'b1;
                    end
                    else if (last_entry)
                    begin
                        fin       = 1'b1;
                        fin_grant = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (fin)
        begin
            state_next = ST_DONE;
        end
    end

    // control state, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg  <= RING_W'(2);
            burnout_reg    <= '0;
            work_reg       <= '0;
            cooldown_reg   <= '0;
            policy_reg     <= 1'b0;
            wait_count_reg <= '0;
            res_vld_reg    <= '0;
            rd_idx_reg     <= '0;
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            granted_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RING:     ring_size_reg <= cfg_data[RING_W-1:0];
                    REG_BURNOUT:  burnout_reg   <= cfg_data[TIME_W-1:0];
                    REG_WORK:     work_reg      <= cfg_data[TIME_W-1:0];
                    REG_COOLDOWN: cooldown_reg  <= cfg_data[TIME_W-1:0];
                    REG_POLICY:   policy_reg    <= cfg_data[0];
                    default:      ;
                endcase
            end
            if (cnt_we)
            begin
                if (32'(wlen_reg) > MAX_USERS)
                begin
                    wait_count_reg <= CW'(MAX_USERS);
                end
                else
                begin
                    wait_count_reg <= CW'(wlen_reg);
                end
            end
            if (res_we)
            begin
                res_vld_reg[IW'(slot_reg)] <= 1'b1;
            end
            if (state_reg == ST_PREP)
            begin
                rd_idx_reg <= '0;
            end
            else if (wl_re)
            begin
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end
            p1_vld_reg <= wl_re && !fin;
            p2_vld_reg <= p1_vld_reg && !fin;
            if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                granted_reg   <= grant_res_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request fields and query datapath
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= op_t'(operation);
            user_reg  <= user_id;
            now_reg   <= now_time;
            last_reg  <= last_start_time;
            slot_reg  <= slot;
            flag_reg  <= taken_flag;
            fat_reg   <= free_at_time;
            entry_reg <= entry_user;
            wlen_reg  <= wait_length;
        end
        if (state_reg == ST_DECODE)
        begin
            left_reg     <= RING_W'(user_reg);
            right_reg    <= right_calc;
            ring_eff_reg <= ring_eff;
            user_out_reg <= RING_W'(user_reg) >= ring_eff;
            lived_reg    <= now_reg - last_reg;
            margin_reg   <= margin_calc;
        end
        if (state_reg == ST_RESOURCE)
        begin
            res_ok_reg   <= !taken_l && !taken_r && (now_reg >= fa_l) && (now_reg >= fa_r);
            lived_ge_reg <= lived_reg >= burnout_reg;
            left_t_reg   <= burnout_reg - lived_reg;
        end
        if (state_reg == ST_PREP)
        begin
            doom_base_reg <= lived_ge_reg || (left_t_reg <= TIME_W'(margin_reg));
            thr_reg       <= left_t_reg - TIME_W'(margin_reg);
            sum_reg       <= work_reg + cooldown_reg;
            need_reg      <= work_reg + cooldown_reg;
        end
        else if (state_reg == ST_SCAN && p2_vld_reg)
        begin
            need_reg <= need_reg + sum_reg;
        end
        if (wl_re)
        begin
            p1_idx_reg <= rd_idx_reg[IW-1:0];
        end
        p2_idx_reg <= p1_idx_reg;
        w2_reg     <= wl_q;
        if (fin)
        begin
            grant_res_reg <= fin_grant;
        end
    end

    // resource memory, two read ports
    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[IW'(slot_reg)] <= {flag_reg, fat_reg};
        end
        if (res_re)
        begin
            res_l_q   <= res_mem[ra_l];
            res_r_q   <= res_mem[ra_r];
            vld_l_reg <= res_vld_reg[ra_l];
            vld_r_reg <= res_vld_reg[ra_r];
        end
    end

    // wait list memory
    always_ff @(posedge clk)
    begin
        if (wl_we)
        begin
            wl_mem[IW'(slot_reg)] <= entry_reg;
        end
        if (wl_re)
        begin
            wl_q <= wl_mem[rd_idx_reg[IW-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign granted   = granted_reg;

`ifndef NO_ASSERTIONS
    a_write_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECODE && op_reg != OP_QUERY) |=>
            (state_reg == ST_DONE && !grant_res_reg))
        else $error("write request produced a grant");

    a_scan_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        wl_re |-> (state_reg == ST_SCAN && rd_idx_reg < wait_count_reg))
        else $error("wait list read beyond wait count");

    a_check_range: assert property (@(posedge clk) disable iff (!rst_n)
        p2_vld_reg |-> (CW'(p2_idx_reg) < wait_count_reg))
        else $error("wait entry checked beyond wait count");

    a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (p2_vld_reg && state_reg == ST_SCAN) |-> (wn_q < ring_eff_reg))
        else $error("ring neighbor outside ring");
`endif

endmodule
